// File: hdl/scld_pkg.sv
package scld_pkg;

   // Frame length limit: pixels past 2**PIXEL_COUNT_BITS are ignored.
   localparam int PIXEL_COUNT_BITS = 24;
   localparam int PIXEL_TOTAL_BITS = PIXEL_COUNT_BITS + 1;

   localparam int COLOR_BITS       = 8;
   localparam int COLOR_TOTAL_BITS = 32;
   localparam int LEVEL_BITS       = 8;
   localparam int CHANGE_BITS      = 10;
   localparam int THRESHOLD_BITS   = 8;
   localparam int PERCENT_BITS     = 8;
   localparam int STRIDE_BITS      = 13;
   localparam int PHASE_BITS       = 12;

   // Shared multiplier and the end-of-frame arithmetic.
   localparam int MUL_A_BITS   = 32;
   localparam int MUL_B_BITS   = 16;
   localparam int PRODUCT_BITS = MUL_A_BITS + MUL_B_BITS;
   localparam int WSUM_BITS    = 48;
   localparam int HALF_BITS    = WSUM_BITS / 2;
   localparam int SCALED_BITS  = 60;
   localparam int FRAC_BITS    = 16;
   localparam int QUOT_BITS    = SCALED_BITS - FRAC_BITS;
   localparam int RAW_BITS     = 10;
   localparam int OFFSET_BITS  = 10;
   localparam int LSUM_BITS    = 12;
   localparam int STEP_BITS    = $clog2(QUOT_BITS);

   localparam logic [MUL_B_BITS-1:0] WEIGHT_RED   = 16'd13933;
   localparam logic [MUL_B_BITS-1:0] WEIGHT_GREEN = 16'd46871;
   localparam logic [MUL_B_BITS-1:0] WEIGHT_BLUE  = 16'd4732;

   localparam logic [STRIDE_BITS-1:0] MAX_STRIDE = 13'd4096;

   // Percent to level offset: floor(x / 100) = (x * OFFSET_RECIP) >> OFFSET_SHIFT
   // for every x = |percent| * 255 the register can produce.
   localparam logic [15:0] OFFSET_RECIP = 16'd41944;
   localparam int          OFFSET_SHIFT = 22;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 13;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   localparam csr_index_type CSR_OFFSET_PERCENT   = 2'd0;
   localparam csr_index_type CSR_SAMPLE_STRIDE    = 2'd1;
   localparam csr_index_type CSR_CHANGE_THRESHOLD = 2'd2;

   localparam logic [PERCENT_BITS-1:0]   RESET_OFFSET_PERCENT   = 8'd0;
   localparam logic [STRIDE_BITS-1:0]    RESET_SAMPLE_STRIDE    = 13'd1024;
   localparam logic [THRESHOLD_BITS-1:0] RESET_CHANGE_THRESHOLD = 8'd8;
   localparam logic [LEVEL_BITS-1:0]     RESET_PREVIOUS_LEVEL   = 8'd255;

   typedef logic [2:0] mul_sel_type;
   localparam mul_sel_type MUL_RED   = 3'd0;
   localparam mul_sel_type MUL_GREEN = 3'd1;
   localparam mul_sel_type MUL_BLUE  = 3'd2;
   localparam mul_sel_type MUL_WLO   = 3'd3;
   localparam mul_sel_type MUL_WHI   = 3'd4;

   typedef logic [1:0] wsum_op_type;
   localparam wsum_op_type WSUM_HOLD = 2'd0;
   localparam wsum_op_type WSUM_LOAD = 2'd1;
   localparam wsum_op_type WSUM_ADD  = 2'd2;

   typedef logic [1:0] scaled_op_type;
   localparam scaled_op_type SCALED_HOLD   = 2'd0;
   localparam scaled_op_type SCALED_LOAD   = 2'd1;
   localparam scaled_op_type SCALED_ADD_HI = 2'd2;

   typedef struct packed {
      logic          accum;
      mul_sel_type   mul_sel;
      wsum_op_type   wsum_op;
      scaled_op_type scaled_op;
      logic          div_load;
      logic          div_step;
      logic          level_load;
      logic          finish;
   } dp_cmd_type;

   typedef struct packed {
      logic emit;
      logic out_blocked;
   } dp_status_type;

endpackage

// File: hdl/scld_ctrl.sv
module scld_ctrl
   import scld_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_frame_end,
   output logic          req_stall,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MUL    = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_LEVEL  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   localparam logic [STEP_BITS-1:0] MUL_LAST = STEP_BITS'(7);
   localparam logic [STEP_BITS-1:0] DIV_LAST = STEP_BITS'(QUOT_BITS - 1);

   logic [2:0]           state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      cmd           = '0;
      cmd.mul_sel   = MUL_RED;
      cmd.wsum_op   = WSUM_HOLD;
      cmd.scaled_op = SCALED_HOLD;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accum = req_valid;
            if (req_valid && req_frame_end) begin
               state_in = ST_MUL;
               step_in  = '0;
            end
         end
         ST_MUL: begin
            // The multiplier output is registered, so each product is
            // folded in one step after its operands were selected.
            unique case (step_ff)
               STEP_BITS'(0): cmd.mul_sel = MUL_RED;
               STEP_BITS'(1): begin
                  cmd.mul_sel = MUL_GREEN;
                  cmd.wsum_op = WSUM_LOAD;
               end
               STEP_BITS'(2): begin
                  cmd.mul_sel = MUL_BLUE;
                  cmd.wsum_op = WSUM_ADD;
               end
               STEP_BITS'(3): cmd.wsum_op = WSUM_ADD;
               STEP_BITS'(4): cmd.mul_sel = MUL_WLO;
               STEP_BITS'(5): begin
                  cmd.mul_sel   = MUL_WHI;
                  cmd.scaled_op = SCALED_LOAD;
               end
               STEP_BITS'(6): cmd.scaled_op = SCALED_ADD_HI;
               default:       cmd.div_load  = 1'b1;
            endcase
            if (step_ff == MUL_LAST) begin
               state_in = ST_DIV;
               step_in  = '0;
            end else begin
               step_in = step_ff + STEP_BITS'(1);
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == DIV_LAST) begin
               state_in = ST_LEVEL;
               step_in  = '0;
            end else begin
               step_in = step_ff + STEP_BITS'(1);
            end
         end
         ST_LEVEL: begin
            cmd.level_load = 1'b1;
            state_in       = ST_FINISH;
         end
         ST_FINISH: begin
            if (!(status.emit && status.out_blocked)) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            step_in  = '0;
         end
      endcase
   end

endmodule

// File: hdl/scld_datapath.sv
module scld_datapath
   import scld_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  dp_cmd_type                cmd,
   output dp_status_type             status,
   input  logic [COLOR_BITS-1:0]     red_value,
   input  logic [COLOR_BITS-1:0]     green_value,
   input  logic [COLOR_BITS-1:0]     blue_value,
   input  logic                      csr_write,
   input  csr_index_type             csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output logic [LEVEL_BITS-1:0]     rsp_screen_level
);

   // Configuration registers.
   logic [PERCENT_BITS-1:0]   offset_percent_ff;
   logic [STRIDE_BITS-1:0]    sample_stride_ff;
   logic [THRESHOLD_BITS-1:0] change_threshold_ff;

   // Frame accumulation state.
   logic [COLOR_TOTAL_BITS-1:0] red_total_ff, red_total_in;
   logic [COLOR_TOTAL_BITS-1:0] green_total_ff, green_total_in;
   logic [COLOR_TOTAL_BITS-1:0] blue_total_ff, blue_total_in;
   logic [PIXEL_TOTAL_BITS-1:0] pixel_total_ff, pixel_total_in;
   logic [PHASE_BITS-1:0]       stride_phase_ff, stride_phase_in;
   logic [LEVEL_BITS-1:0]       previous_level_ff;
   logic [CHANGE_BITS-1:0]      change_total_ff;

   // End-of-frame arithmetic.
   logic [PRODUCT_BITS-1:0]     product_ff;
   logic [WSUM_BITS-1:0]        wsum_ff;
   logic [SCALED_BITS-1:0]      scaled_ff;
   logic [QUOT_BITS-1:0]        quot_ff;
   logic [PIXEL_TOTAL_BITS-1:0] rem_ff;
   logic [LEVEL_BITS-1:0]       level_ff, level_in;
   logic signed [OFFSET_BITS-1:0] offset_ff;

   logic                      rsp_valid_ff;
   logic [LEVEL_BITS-1:0]     rsp_level_ff;

   logic [STRIDE_BITS-1:0]    eff_stride;
   logic [STRIDE_BITS-1:0]    phase_next;
   logic                      room;
   logic [MUL_A_BITS-1:0]     mul_a;
   logic [MUL_B_BITS-1:0]     mul_b;
   logic [PIXEL_TOTAL_BITS:0] div_shifted;
   logic [PIXEL_TOTAL_BITS:0] div_diff;
   logic                      div_ge;
   logic [RAW_BITS-1:0]       raw_level;
   logic signed [LSUM_BITS-1:0] level_sum;
   logic [LEVEL_BITS-1:0]     level_diff;
   logic [CHANGE_BITS-1:0]    change_sum;
   logic                      emit;
   logic                      rsp_load;
   logic [PERCENT_BITS-1:0]   percent_mag;
   logic [15:0]               percent_scaled;
   logic [31:0]               offset_product;
   logic [OFFSET_BITS-1:0]    offset_mag;

   function automatic logic [COLOR_TOTAL_BITS-1:0] sat_add(
      input logic [COLOR_TOTAL_BITS-1:0] total,
      input logic [COLOR_BITS-1:0]       value
   );
      logic [COLOR_TOTAL_BITS:0] sum;
      sum = {1'b0, total} + (COLOR_TOTAL_BITS + 1)'(value);
      return sum[COLOR_TOTAL_BITS] ? '1 : sum[COLOR_TOTAL_BITS-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_percent_ff   <= RESET_OFFSET_PERCENT;
         sample_stride_ff    <= RESET_SAMPLE_STRIDE;
         change_threshold_ff <= RESET_CHANGE_THRESHOLD;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_OFFSET_PERCENT:   offset_percent_ff   <= csr_wdata[PERCENT_BITS-1:0];
            CSR_SAMPLE_STRIDE:    sample_stride_ff    <= csr_wdata;
            CSR_CHANGE_THRESHOLD: change_threshold_ff <= csr_wdata[THRESHOLD_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Level offset, trunc(percent * 255 / 100), kept up to date from the register.
   assign percent_mag    = offset_percent_ff[PERCENT_BITS-1] ? (~offset_percent_ff + 8'd1)
                                                             : offset_percent_ff;
   assign percent_scaled = {percent_mag, 8'd0} - {8'd0, percent_mag};
   assign offset_product = {16'd0, percent_scaled} * {16'd0, OFFSET_RECIP};
   assign offset_mag     = offset_product[OFFSET_SHIFT +: OFFSET_BITS];

   always_ff @(posedge clock) begin
      offset_ff <= offset_percent_ff[PERCENT_BITS-1] ? -$signed(offset_mag)
                                                     : $signed(offset_mag);
   end

   // Pixel accumulation.
   always_comb begin
      if (sample_stride_ff == '0) begin
         eff_stride = STRIDE_BITS'(1);
      end else if (sample_stride_ff > MAX_STRIDE) begin
         eff_stride = MAX_STRIDE;
      end else begin
         eff_stride = sample_stride_ff;
      end
   end

   assign phase_next = {1'b0, stride_phase_ff} + STRIDE_BITS'(1);
   assign room       = !pixel_total_ff[PIXEL_TOTAL_BITS-1];

   always_comb begin
      red_total_in    = red_total_ff;
      green_total_in  = green_total_ff;
      blue_total_in   = blue_total_ff;
      pixel_total_in  = pixel_total_ff;
      stride_phase_in = stride_phase_ff;
      priority if (cmd.finish) begin
         red_total_in    = '0;
         green_total_in  = '0;
         blue_total_in   = '0;
         pixel_total_in  = '0;
         stride_phase_in = '0;
      end else if (cmd.accum && room) begin
         if (stride_phase_ff == '0) begin
            red_total_in   = sat_add(red_total_ff, red_value);
            green_total_in = sat_add(green_total_ff, green_value);
            blue_total_in  = sat_add(blue_total_ff, blue_value);
         end
         pixel_total_in  = pixel_total_ff + PIXEL_TOTAL_BITS'(1);
         stride_phase_in = (phase_next >= eff_stride) ? '0 : phase_next[PHASE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_total_ff    <= '0;
         green_total_ff  <= '0;
         blue_total_ff   <= '0;
         pixel_total_ff  <= '0;
         stride_phase_ff <= '0;
      end else begin
         red_total_ff    <= red_total_in;
         green_total_ff  <= green_total_in;
         blue_total_ff   <= blue_total_in;
         pixel_total_ff  <= pixel_total_in;
         stride_phase_ff <= stride_phase_in;
      end
   end

   // Shared multiplier: the weighted sum, then its two halves times the stride.
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_RED: begin
            mul_a = red_total_ff;
            mul_b = WEIGHT_RED;
         end
         MUL_GREEN: begin
            mul_a = green_total_ff;
            mul_b = WEIGHT_GREEN;
         end
         MUL_BLUE: begin
            mul_a = blue_total_ff;
            mul_b = WEIGHT_BLUE;
         end
         MUL_WLO: begin
            mul_a = MUL_A_BITS'(wsum_ff[HALF_BITS-1:0]);
            mul_b = MUL_B_BITS'(eff_stride);
         end
         MUL_WHI: begin
            mul_a = MUL_A_BITS'(wsum_ff[WSUM_BITS-1:HALF_BITS]);
            mul_b = MUL_B_BITS'(eff_stride);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      product_ff <= {{MUL_B_BITS{1'b0}}, mul_a} * {{MUL_A_BITS{1'b0}}, mul_b};
      unique case (cmd.wsum_op)
         WSUM_LOAD: wsum_ff <= product_ff[WSUM_BITS-1:0];
         WSUM_ADD:  wsum_ff <= wsum_ff + product_ff[WSUM_BITS-1:0];
         default: ;
      endcase
      unique case (cmd.scaled_op)
         SCALED_LOAD:   scaled_ff <= SCALED_BITS'(product_ff);
         SCALED_ADD_HI: scaled_ff <= scaled_ff +
            {product_ff[SCALED_BITS-HALF_BITS-1:0], {HALF_BITS{1'b0}}};
         default: ;
      endcase
   end

   // Restoring division of the scaled sum by the pixel count, one bit a step.
   assign div_shifted = {rem_ff, quot_ff[QUOT_BITS-1]};
   assign div_diff    = div_shifted - {1'b0, pixel_total_ff};
   assign div_ge      = (div_shifted >= {1'b0, pixel_total_ff});

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff  <= '0;
         quot_ff <= scaled_ff[SCALED_BITS-1:FRAC_BITS];
      end else if (cmd.div_step) begin
         rem_ff  <= div_ge ? div_diff[PIXEL_TOTAL_BITS-1:0]
                           : div_shifted[PIXEL_TOTAL_BITS-1:0];
         quot_ff <= {quot_ff[QUOT_BITS-2:0], div_ge};
      end
   end

   // Quotients past the raw field saturate; the clamp below hides the difference.
   always_comb begin
      if (pixel_total_ff == '0) begin
         raw_level = '0;
      end else if (quot_ff[QUOT_BITS-1:RAW_BITS] != '0) begin
         raw_level = '1;
      end else begin
         raw_level = quot_ff[RAW_BITS-1:0];
      end
      level_sum = $signed({{(LSUM_BITS-RAW_BITS){1'b0}}, raw_level}) +
                  LSUM_BITS'(offset_ff);
      if (level_sum < 0) begin
         level_in = '0;
      end else if (level_sum > $signed(LSUM_BITS'(255))) begin
         level_in = '1;
      end else begin
         level_in = level_sum[LEVEL_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.level_load) begin
         level_ff <= level_in;
      end
   end

   assign level_diff = (level_ff > previous_level_ff) ? level_ff - previous_level_ff
                                                      : previous_level_ff - level_ff;
   assign change_sum = change_total_ff + CHANGE_BITS'(level_diff);
   assign emit       = (change_sum > CHANGE_BITS'(change_threshold_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         previous_level_ff <= RESET_PREVIOUS_LEVEL;
         change_total_ff   <= '0;
      end else if (cmd.finish) begin
         previous_level_ff <= level_ff;
         change_total_ff   <= emit ? '0 : change_sum;
      end
   end

   // Output word register.
   assign rsp_load = cmd.finish && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_level_ff <= level_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_screen_level   = rsp_level_ff;
   assign status.emit        = emit;
   assign status.out_blocked = rsp_valid_ff && rsp_stall;

endmodule

// File: hdl/screen_luma_change_detector.sv
// Pixels are taken one per cycle while no frame is being finished.
// A frame_end word stalls the input through 8 multiply steps on one
// shared multiplier, 44 bit-serial divider steps, a level and an update
// step, longer if a result word is due while the last is still stalled.
// The new result word is valid on the cycle after the update.
// Synchronous active-high reset clears the totals, restores the register
// defaults and sets the previous level to 255.
module screen_luma_change_detector
   import scld_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [COLOR_BITS-1:0]    req_red_value,
   input  logic [COLOR_BITS-1:0]    req_green_value,
   input  logic [COLOR_BITS-1:0]    req_blue_value,
   input  logic                     req_frame_end,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [LEVEL_BITS-1:0]    rsp_screen_level,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  csr_index_type            csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   scld_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_frame_end (req_frame_end),
      .req_stall     (req_stall),
      .cmd           (cmd),
      .status        (status)
   );

   scld_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .red_value        (req_red_value),
      .green_value      (req_green_value),
      .blue_value       (req_blue_value),
      .csr_write        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_screen_level (rsp_screen_level)
   );

   a_frame_end_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_frame_end |=> req_stall)
      else $error("frame end did not start the level computation");

   a_pixel_keeps_flowing: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_frame_end |=> !req_stall)
      else $error("input stalled after an ordinary pixel");

   a_result_after_frame: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result word appeared outside the frame end computation");

endmodule

// File: dv/scld_level_checker.sv
module scld_level_checker
   import scld_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [COLOR_BITS-1:0]    req_red_value,
   input  logic [COLOR_BITS-1:0]    req_green_value,
   input  logic [COLOR_BITS-1:0]    req_blue_value,
   input  logic                     req_frame_end,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [LEVEL_BITS-1:0]    rsp_screen_level,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  csr_index_type            csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output int                       mismatch_count,
   output int                       levels_pending,
   output int                       levels_received
);

   localparam logic [PIXEL_TOTAL_BITS-1:0] PIXEL_CAP = {1'b1, {PIXEL_COUNT_BITS{1'b0}}};

   logic signed [PERCENT_BITS-1:0]  offset_percent;
   logic [STRIDE_BITS-1:0]          sample_stride;
   logic [THRESHOLD_BITS-1:0]       change_threshold;

   logic [COLOR_TOTAL_BITS-1:0]     red_sum;
   logic [COLOR_TOTAL_BITS-1:0]     green_sum;
   logic [COLOR_TOTAL_BITS-1:0]     blue_sum;
   logic [PIXEL_TOTAL_BITS-1:0]     pixels_in_frame;
   logic [PHASE_BITS-1:0]           sample_phase;
   logic [LEVEL_BITS-1:0]           last_level;
   logic [CHANGE_BITS-1:0]          change_sum;

   logic [LEVEL_BITS-1:0]           levels_due[$];
   int                              mismatches;
   int                              received;

   function automatic logic [STRIDE_BITS-1:0] stride_in_use();
      if (sample_stride == '0) begin
         return STRIDE_BITS'(1);
      end
      if (sample_stride > MAX_STRIDE) begin
         return MAX_STRIDE;
      end
      return sample_stride;
   endfunction

   function automatic logic [COLOR_TOTAL_BITS-1:0] add_saturating(
      input logic [COLOR_TOTAL_BITS-1:0] total,
      input logic [COLOR_BITS-1:0]       channel_value
   );
      logic [COLOR_TOTAL_BITS:0] wide;
      wide = {1'b0, total} + (COLOR_TOTAL_BITS + 1)'(channel_value);
      return wide[COLOR_TOTAL_BITS] ? '1 : wide[COLOR_TOTAL_BITS-1:0];
   endfunction

   // Average luma of the sampled pixels, scaled back up by the stride, plus the offset.
   function automatic logic [LEVEL_BITS-1:0] frame_level();
      logic [63:0] weighted;
      logic [63:0] denom;
      longint      raw;
      longint      level;
      raw = 0;
      if (pixels_in_frame != '0) begin
         weighted = 64'(red_sum) * 64'(WEIGHT_RED) + 64'(green_sum) * 64'(WEIGHT_GREEN)
                  + 64'(blue_sum) * 64'(WEIGHT_BLUE);
         denom = 64'(pixels_in_frame) << FRAC_BITS;
         raw = longint'((weighted * 64'(stride_in_use())) / denom);
      end
      // Integer division truncates toward zero, as the offset scaling requires.
      level = raw + longint'((int'(offset_percent) * 255) / 100);
      if (level < 0) begin
         level = 0;
      end
      if (level > 255) begin
         level = 255;
      end
      return level[LEVEL_BITS-1:0];
   endfunction

   task automatic take_pixel(
      input logic [COLOR_BITS-1:0] red,
      input logic [COLOR_BITS-1:0] green,
      input logic [COLOR_BITS-1:0] blue,
      input logic                  last
   );
      logic [STRIDE_BITS-1:0] next_phase;
      logic [LEVEL_BITS-1:0]  level;
      logic [LEVEL_BITS-1:0]  change;
      // Pixels past the frame length limit are dropped, but their frame_end still counts.
      if (pixels_in_frame < PIXEL_CAP) begin
         if (sample_phase == '0) begin
            red_sum   = add_saturating(red_sum, red);
            green_sum = add_saturating(green_sum, green);
            blue_sum  = add_saturating(blue_sum, blue);
         end
         pixels_in_frame = pixels_in_frame + 1'b1;
         next_phase = STRIDE_BITS'(sample_phase) + 1'b1;
         sample_phase = (next_phase >= stride_in_use()) ? '0 : next_phase[PHASE_BITS-1:0];
      end
      if (last) begin
         level = frame_level();
         change = (level > last_level) ? level - last_level : last_level - level;
         change_sum = change_sum + CHANGE_BITS'(change);
         last_level = level;
         if (change_sum > CHANGE_BITS'(change_threshold)) begin
            change_sum = '0;
            levels_due.push_back(level);
         end
         red_sum = '0;
         green_sum = '0;
         blue_sum = '0;
         pixels_in_frame = '0;
         sample_phase = '0;
      end
   endtask

   always @(posedge clock) begin : watch
      logic [LEVEL_BITS-1:0] expected;
      if (reset) begin
         offset_percent = RESET_OFFSET_PERCENT;
         sample_stride = RESET_SAMPLE_STRIDE;
         change_threshold = RESET_CHANGE_THRESHOLD;
         red_sum = '0;
         green_sum = '0;
         blue_sum = '0;
         pixels_in_frame = '0;
         sample_phase = '0;
         last_level = RESET_PREVIOUS_LEVEL;
         change_sum = '0;
         levels_due.delete();
         mismatches = 0;
         received = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_OFFSET_PERCENT: begin
                  offset_percent = csr_wdata[PERCENT_BITS-1:0];
               end
               CSR_SAMPLE_STRIDE: begin
                  sample_stride = csr_wdata[STRIDE_BITS-1:0];
               end
               CSR_CHANGE_THRESHOLD: begin
                  change_threshold = csr_wdata[THRESHOLD_BITS-1:0];
               end
               default: begin
               end
            endcase
         end
         if (req_valid && !req_stall) begin
            take_pixel(req_red_value, req_green_value, req_blue_value, req_frame_end);
         end
         if (rsp_valid && !rsp_stall) begin
            received++;
            if (levels_due.size() == 0) begin
               $display("%0t: screen_level expected none, got %0d", $time, rsp_screen_level);
               mismatches++;
            end else begin
               expected = levels_due.pop_front();
               if (rsp_screen_level !== expected) begin
                  $display("%0t: screen_level expected %0d, got %0d", $time, expected,
                           rsp_screen_level);
                  mismatches++;
               end
            end
         end
      end
      mismatch_count  <= mismatches;
      levels_pending  <= levels_due.size();
      levels_received <= received;
   end

endmodule

// File: dv/tb_top.sv
module tb_top
   import scld_pkg::*;
();

   // A frame_end word keeps the block busy through its multiply, divide, level and update steps, plus any output stall.
   localparam int FRAME_DRAIN_CYCLES = 64;
   localparam int RANDOM_PIXELS      = 800;
   localparam csr_index_type CSR_UNUSED_INDEX = 2'd3;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [COLOR_BITS-1:0]    req_red_value;
   logic [COLOR_BITS-1:0]    req_green_value;
   logic [COLOR_BITS-1:0]    req_blue_value;
   logic                     req_frame_end;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [LEVEL_BITS-1:0]    rsp_screen_level;
   logic                     csr_valid;
   logic                     csr_ready;
   csr_index_type            csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   int mismatch_count;
   int levels_pending;
   int levels_received;
   bit steady_flow;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   screen_luma_change_detector dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_red_value    (req_red_value),
      .req_green_value  (req_green_value),
      .req_blue_value   (req_blue_value),
      .req_frame_end    (req_frame_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_screen_level (rsp_screen_level),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   scld_level_checker level_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_red_value    (req_red_value),
      .req_green_value  (req_green_value),
      .req_blue_value   (req_blue_value),
      .req_frame_end    (req_frame_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_screen_level (rsp_screen_level),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatch_count),
      .levels_pending   (levels_pending),
      .levels_received  (levels_received)
   );

   task automatic send_pixel(
      input logic [COLOR_BITS-1:0] red,
      input logic [COLOR_BITS-1:0] green,
      input logic [COLOR_BITS-1:0] blue,
      input logic                  last
   );
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_red_value   <= red;
      req_green_value <= green;
      req_blue_value  <= blue;
      req_frame_end   <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Mostly one base color with some random pixels mixed in, so levels swing widely.
   task automatic send_frame(input int length);
      logic [COLOR_BITS-1:0] base_red;
      logic [COLOR_BITS-1:0] base_green;
      logic [COLOR_BITS-1:0] base_blue;
      int                    shade;
      base_red   = COLOR_BITS'($urandom_range(0, 255));
      base_green = COLOR_BITS'($urandom_range(0, 255));
      base_blue  = COLOR_BITS'($urandom_range(0, 255));
      shade = $urandom_range(0, 5);
      if (shade == 0) begin
         {base_red, base_green, base_blue} = '0;
      end else if (shade == 1) begin
         {base_red, base_green, base_blue} = '1;
      end
      for (int i = 0; i < length; i++) begin
         if ($urandom_range(0, 3) == 0) begin
            send_pixel(COLOR_BITS'($urandom_range(0, 255)), COLOR_BITS'($urandom_range(0, 255)),
                       COLOR_BITS'($urandom_range(0, 255)), i == length - 1);
         end else begin
            send_pixel(base_red, base_green, base_blue, i == length - 1);
         end
      end
   endtask

   // Wait until every expected level has arrived and the last frame is fully finished.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (levels_pending != 0) @(posedge clock);
      repeat (FRAME_DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type index, input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Result side: stall each level word for a random number of cycles while it is offered.
   initial begin : result_sink
      int hold;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         hold = steady_flow ? 0 : $urandom_range(0, 8);
         rsp_stall <= (hold != 0);
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) begin
            if (rsp_valid && hold > 0) begin
               hold--;
            end
            if (hold == 0) begin
               rsp_stall <= 1'b0;
            end
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int pixels_sent;
      int phase_pixels;
      int length;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_red_value   <= '0;
      req_green_value <= '0;
      req_blue_value  <= '0;
      req_frame_end   <= 1'b0;
      csr_valid       <= 1'b0;
      csr_index       <= CSR_OFFSET_PERCENT;
      csr_wdata       <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset registers: white matches the initial level of 255, black is a full swing.
      send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b1);

      settle();
      write_reg(CSR_SAMPLE_STRIDE, 13'd1);
      write_reg(CSR_CHANGE_THRESHOLD, 13'd0);
      write_reg(CSR_OFFSET_PERCENT, 13'd0);
      write_reg(CSR_UNUSED_INDEX, '1);
      send_pixel(8'd255, 8'd0, 8'd0, 1'b1);
      send_pixel(8'd0, 8'd255, 8'd0, 1'b1);
      send_pixel(8'd0, 8'd0, 8'd255, 1'b1);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
      // An unchanged level never exceeds even a zero threshold.
      send_pixel(8'd0, 8'd0, 8'd0, 1'b1);

      settle();
      write_reg(CSR_OFFSET_PERCENT, 13'd100);
      send_pixel(8'd128, 8'd128, 8'd128, 1'b1);
      settle();
      write_reg(CSR_OFFSET_PERCENT, 13'(-100));
      send_pixel(8'd128, 8'd128, 8'd128, 1'b1);
      settle();
      write_reg(CSR_OFFSET_PERCENT, 13'd127);
      send_pixel(8'd64, 8'd64, 8'd64, 1'b1);
      settle();
      write_reg(CSR_OFFSET_PERCENT, 13'(-128));
      send_pixel(8'd200, 8'd200, 8'd200, 1'b1);

      settle();
      write_reg(CSR_OFFSET_PERCENT, 13'd0);
      write_reg(CSR_CHANGE_THRESHOLD, 13'd255);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b1);

      // Strides outside the legal range are pinned to 1 and 4096.
      settle();
      write_reg(CSR_CHANGE_THRESHOLD, 13'd0);
      write_reg(CSR_SAMPLE_STRIDE, 13'd0);
      send_pixel(8'd10, 8'd90, 8'd30, 1'b0);
      send_pixel(8'd250, 8'd240, 8'd230, 1'b1);
      settle();
      write_reg(CSR_SAMPLE_STRIDE, 13'h1FFF);
      send_pixel(8'd1, 8'd1, 8'd1, 1'b0);
      send_pixel(8'd200, 8'd100, 8'd50, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
      settle();
      write_reg(CSR_SAMPLE_STRIDE, 13'd4097);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b1);

      // Shorten the stride mid-frame while the phase is already past the new stride.
      settle();
      write_reg(CSR_SAMPLE_STRIDE, 13'd4);
      send_pixel(8'd40, 8'd80, 8'd120, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      settle();
      write_reg(CSR_SAMPLE_STRIDE, 13'd2);
      send_pixel(8'd90, 8'd20, 8'd70, 1'b0);
      send_pixel(8'd33, 8'd66, 8'd99, 1'b0);
      send_pixel(8'd180, 8'd10, 8'd240, 1'b1);

      pixels_sent = 0;
      while (pixels_sent < RANDOM_PIXELS) begin
         settle();
         steady_flow = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 5))
            0: write_reg(CSR_OFFSET_PERCENT, 13'(-128));
            1: write_reg(CSR_OFFSET_PERCENT, 13'd127);
            2: write_reg(CSR_OFFSET_PERCENT, $urandom_range(0, 1) ? 13'd100 : 13'(-100));
            3: write_reg(CSR_OFFSET_PERCENT, 13'($urandom_range(0, 8191)));
            default: write_reg(CSR_OFFSET_PERCENT, 13'($urandom_range(0, 40) - 20));
         endcase
         case ($urandom_range(0, 7))
            0: write_reg(CSR_SAMPLE_STRIDE, 13'd0);
            1: write_reg(CSR_SAMPLE_STRIDE, 13'($urandom_range(4097, 8191)));
            2: write_reg(CSR_SAMPLE_STRIDE, 13'd4096);
            3, 4, 5: write_reg(CSR_SAMPLE_STRIDE, 13'($urandom_range(1, 4)));
            default: write_reg(CSR_SAMPLE_STRIDE, 13'($urandom_range(5, 64)));
         endcase
         case ($urandom_range(0, 4))
            0: write_reg(CSR_CHANGE_THRESHOLD, 13'd0);
            1: write_reg(CSR_CHANGE_THRESHOLD, 13'd255);
            2: write_reg(CSR_CHANGE_THRESHOLD, 13'($urandom_range(0, 255)));
            default: write_reg(CSR_CHANGE_THRESHOLD, 13'($urandom_range(0, 40)));
         endcase
         phase_pixels = 0;
         while (phase_pixels < 60) begin
            length = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 200)
                                                 : $urandom_range(1, 16);
            send_frame(length);
            phase_pixels += length;
         end
         pixels_sent += phase_pixels;
      end

      settle();
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
